/* sv/aed_pkg.sv */
// ----------------------------------------------------------------------------
// aed_pkg
// Shared types and codes for the asymmetric edge debouncer.
// ----------------------------------------------------------------------------
package aed_pkg;

	// Filtered and raw level codes.
	localparam logic [1:0] ST_UNDEF = 2'd0;
	localparam logic [1:0] ST_LOW   = 2'd1;
	localparam logic [1:0] ST_HIGH  = 2'd2;

	// Item operation codes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_DELAY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_DELAY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_INPUT = 2'd2;

	localparam int unsigned CFG_DATA_W = 16;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] rise_delay;
		logic [CFG_DATA_W-1:0] fall_delay;
		logic                  invert_input;
	} cfg_t;

	typedef struct packed {
		logic [1:0] filtered_state;
		logic       state_changed;
	} res_t;

	// Swap low and high; undefined stays undefined.
	function automatic logic [1:0] opposite(input logic [1:0] s);
		logic [1:0] r;
		r = ST_UNDEF;
		if (s == ST_LOW)
			r = ST_HIGH;
		else if (s == ST_HIGH)
			r = ST_LOW;
		return r;
	endfunction

endpackage

/* sv/aed_cfg.sv */
// ----------------------------------------------------------------------------
// aed_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module aed_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [aed_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [aed_pkg::CFG_DATA_W-1:0]  wr_data,
	output aed_pkg::cfg_t                   cfg
);
	import aed_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RISE_DELAY:   cfg_q.rise_delay   <= wr_data;
				REG_FALL_DELAY:   cfg_q.fall_delay   <= wr_data;
				REG_INVERT_INPUT: cfg_q.invert_input <= wr_data[0];
				default: ; // Writes beyond the register list are dropped.
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/aed_core.sv */
// ----------------------------------------------------------------------------
// aed_core
// Filter state and its combinational update for one accepted item.
// ----------------------------------------------------------------------------
module aed_core #(
	parameter int unsigned DELAY_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  aed_pkg::cfg_t  cfg,
	input  logic           accept,
	input  logic           operation,
	input  logic           pin_level,
	output aed_pkg::res_t  res
);
	import aed_pkg::*;

	localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_BITS) - 33'd1;

	logic [1:0]            filtered_q, filtered_d;
	logic [1:0]            last_raw_q, last_raw_d;
	logic [DELAY_BITS-1:0] cnt_q, cnt_d, cnt_dec;
	logic                  run_q, run_d;
	logic                  changed;
	logic [1:0]            s;
	logic [CFG_DATA_W-1:0] delay_raw;
	logic [32:0]           delay_sat;

	always_comb begin
		s         = (pin_level ^ cfg.invert_input) ? ST_HIGH : ST_LOW;
		delay_raw = (s == ST_HIGH) ? cfg.rise_delay : cfg.fall_delay;
		// Clamp the register value to what the countdown can hold.
		delay_sat = (33'(delay_raw) > DELAY_MAX) ? DELAY_MAX : 33'(delay_raw);
		cnt_dec   = (cnt_q != '0) ? cnt_q - DELAY_BITS'(1) : cnt_q;

		filtered_d = filtered_q;
		last_raw_d = last_raw_q;
		cnt_d      = cnt_q;
		run_d      = run_q;
		changed    = 1'b0;

		if (operation == OP_SAMPLE) begin
			if (s != last_raw_q) begin
				last_raw_d = s;
				if (filtered_q == ST_UNDEF) begin
					filtered_d = opposite(s);
					changed    = 1'b1;
				end else if (filtered_q != s) begin
					if (delay_raw != '0) begin
						cnt_d = delay_sat[DELAY_BITS-1:0];
						run_d = 1'b1;
					end else begin
						filtered_d = opposite(filtered_q);
						cnt_d      = '0;
						run_d      = 1'b0;
						changed    = 1'b1;
					end
				end else begin
					cnt_d = '0;
					run_d = 1'b0;
				end
			end
		end else if (run_q) begin
			cnt_d = cnt_dec;
			if (cnt_dec == '0) begin
				run_d      = 1'b0;
				filtered_d = opposite(filtered_q);
				changed    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_q <= ST_UNDEF;
			last_raw_q <= ST_UNDEF;
			cnt_q      <= '0;
			run_q      <= 1'b0;
		end else if (accept) begin
			filtered_q <= filtered_d;
			last_raw_q <= last_raw_d;
			cnt_q      <= cnt_d;
			run_q      <= run_d;
		end
	end

	assign res.filtered_state = filtered_d;
	assign res.state_changed  = changed;

endmodule

/* sv/aed_outbuf.sv */
// ----------------------------------------------------------------------------
// aed_outbuf
// Result register with a skid stage, so input stall is a registered signal.
// ----------------------------------------------------------------------------
module aed_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  aed_pkg::res_t  push_data,
	output logic           full,
	output logic           out_valid,
	input  logic           out_stall,
	output aed_pkg::res_t  out_data
);
	import aed_pkg::*;

	logic main_vld_q, skid_vld_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop = main_vld_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_vld_q) begin
				if (pop) begin
					main_vld_q <= 1'b1;
					skid_vld_q <= 1'b0;
				end
			end else if (push) begin
				if (!main_vld_q || pop)
					main_vld_q <= 1'b1;
				else
					skid_vld_q <= 1'b1;
			end else if (pop) begin
				main_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (!main_vld_q || pop)
				main_q <= push_data;
			else
				skid_q <= push_data;
		end
	end

	assign full      = skid_vld_q;
	assign out_valid = main_vld_q;
	assign out_data  = main_q;

endmodule

/* sv/asymmetric_edge_debouncer.sv */
// ----------------------------------------------------------------------------
// asymmetric_edge_debouncer
// One-pin edge debouncer with separate rise and fall delays counted in ticks.
// ----------------------------------------------------------------------------
// Each result is registered into the result buffer. Throughput: one
// transaction per cycle unless the buffer is full; the filter update is
// a single pass of compares and one decrement between the state registers
// and the result register; a two-entry buffer decouples input and output.
// Reset: arst_n clears the configuration, the filter to undefined, the
// countdown and the result buffer.
// ----------------------------------------------------------------------------
module asymmetric_edge_debouncer #(
	parameter int unsigned DELAY_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write port.
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,

	// Input channel: a sample or a tick per transaction.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic        pin_level,

	// Output channel: one result per input transaction.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  filtered_state,
	output logic        state_changed
);
	import aed_pkg::*;

	cfg_t cfg;
	res_t core_res;
	res_t out_res;
	logic accept;
	logic buf_full;

	// The input side stalls only when both result slots are occupied, so a
	// transaction is taken every cycle while the consumer keeps draining.
	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	aed_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// The filter state advances at the accept edge; the result for the same
	// transaction is captured into the result buffer at that edge as well.
	aed_core #(
		.DELAY_BITS (DELAY_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (accept),
		.operation (operation),
		.pin_level (pin_level),
		.res       (core_res)
	);

	aed_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (core_res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign filtered_state = out_res.filtered_state;
	assign state_changed  = out_res.state_changed;

endmodule

/* bench/tb_asymmetric_edge_debouncer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_asymmetric_edge_debouncer
// Self-checking bench for the one-pin asymmetric edge debouncer. A scoreboard
// class tracks the filter state, the countdown and the registers. It predicts
// the filtered state and change flag for every accepted transaction and
// compares them with the results in order. A short directed opening is
// followed by phases of random edges, bounces and tick runs. Each phase uses
// its own delay settings and one of four mixes of sender idling and receiver
// stalling.
// ----------------------------------------------------------------------------
module tb_asymmetric_edge_debouncer;
	import aed_pkg::*;

	// The block decodes only three registers; index three must be ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int unsigned PHASE_ITEMS = 168;

	// Scoreboard: keeps its own copy of the filter and configuration and
	// a queue of the results still owed by the block.
	class debounce_scoreboard;
		logic [15:0] rise_ticks;
		logic [15:0] fall_ticks;
		logic        invert;
		logic [1:0]  filt;
		logic [1:0]  last_raw;
		logic [15:0] countdown;
		logic        running;
		res_t        expected_levels[$];
		int unsigned errors;

		function new();
			rise_ticks = '0;
			fall_ticks = '0;
			invert     = 1'b0;
			filt       = ST_UNDEF;
			last_raw   = ST_UNDEF;
			countdown  = '0;
			running    = 1'b0;
			errors     = 0;
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [15:0] value);
			case (idx)
				REG_RISE_DELAY: begin
					rise_ticks = value;
				end
				REG_FALL_DELAY: begin
					fall_ticks = value;
				end
				REG_INVERT_INPUT: begin
					invert = value[0];
				end
				default: begin
				end
			endcase
		endfunction

		// Advance the filter by one accepted transaction and queue its result.
		// The countdown is as wide as the delay registers, so no clamp is needed.
		function void note_transaction(input logic op, input logic pin);
			logic [1:0]  level;
			logic [15:0] load;
			res_t        r;
			r.state_changed = 1'b0;
			if (op == OP_SAMPLE) begin
				level = (pin ^ invert) ? ST_HIGH : ST_LOW;
				if (level != last_raw) begin
					last_raw = level;
					if (filt == ST_UNDEF) begin
						// The first edge defines the state as the level before it.
						filt = (level == ST_HIGH) ? ST_LOW : ST_HIGH;
						r.state_changed = 1'b1;
					end else if (filt != level) begin
						load = (level == ST_HIGH) ? rise_ticks : fall_ticks;
						if (load != 0) begin
							countdown = load;
							running   = 1'b1;
						end else begin
							filt      = level;
							countdown = '0;
							running   = 1'b0;
							r.state_changed = 1'b1;
						end
					end else begin
						// Back at the filtered level: the pending edge was a bounce.
						countdown = '0;
						running   = 1'b0;
					end
				end
			end else if (running) begin
				if (countdown != 0)
					countdown = countdown - 16'd1;
				if (countdown == 0) begin
					running = 1'b0;
					filt    = (filt == ST_LOW) ? ST_HIGH : ST_LOW;
					r.state_changed = 1'b1;
				end
			end
			r.filtered_state = filt;
			expected_levels.push_back(r);
		endfunction

		function void check_result(input logic [1:0] fs, input logic ch);
			res_t want;
			if (expected_levels.size() == 0) begin
				errors++;
				$display("%0t: result with none pending: filtered_state %0d state_changed %0d",
					$time, fs, ch);
				return;
			end
			want = expected_levels.pop_front();
			if (fs !== want.filtered_state) begin
				errors++;
				$display("%0t: filtered_state mismatch: expected %0d, actual %0d",
					$time, want.filtered_state, fs);
			end
			if (ch !== want.state_changed) begin
				errors++;
				$display("%0t: state_changed mismatch: expected %0d, actual %0d",
					$time, want.state_changed, ch);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = REG_RISE_DELAY;
	logic [15:0] wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = OP_SAMPLE;
	logic        pin_level = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  filtered_state;
	logic        state_changed;

	// Percentages of cycles in which the sender idles or the receiver stalls.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	debounce_scoreboard sb = new();

	asymmetric_edge_debouncer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.pin_level      (pin_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_state (filtered_state),
		.state_changed  (state_changed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: the outputs are read at the edge, before this edge's updates
	// land, so a result counts exactly when valid was high and stall was low.
	// Stall is redrawn every cycle, independent of valid.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(filtered_state, state_changed);
		out_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	// Present one transaction and hold it until the block takes it. An idle
	// gap lowers valid first; without a gap, valid simply stays high so that
	// back-to-back transactions never see two assignments in one time step.
	task automatic send_item(input logic op, input logic pin);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		operation <= op;
		pin_level <= pin;
		do @(posedge clk); while (in_stall);
		sb.note_transaction(op, pin);
	endtask

	// Stop sending and wait until every owed result has come back. Every
	// transaction yields a result, so an empty queue means the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_levels.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// One register write; the enable stays high for a following write.
	task automatic put_reg(input logic [1:0] idx, input logic [15:0] value);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		sb.write_reg(idx, value);
	endtask

	// Write all registers, then poke the undecoded index with random data,
	// which must leave the settings alone. The invert register gets random
	// upper bits, since only bit zero counts.
	task automatic configure(input logic [15:0] rise, input logic [15:0] fall,
			input logic inv);
		put_reg(REG_RISE_DELAY, rise);
		put_reg(REG_FALL_DELAY, fall);
		put_reg(REG_INVERT_INPUT, {15'($urandom), inv});
		put_reg(REG_UNUSED, 16'($urandom));
		wr_en <= 1'b0;
	endtask

	// Random traffic. Most of it is shaped like a real bouncing pin: an edge
	// away from the filtered level, sometimes a bounce back and forth, then a
	// run of up to twelve ticks that reaches the delay only if it is short. The rest
	// is unstructured noise, which also covers ticks with no countdown running
	// and samples that repeat the previous level.
	task automatic run_random(input int unsigned n_items);
		int unsigned sent;
		int unsigned ticks;
		logic [1:0]  goal;
		logic [15:0] hold;
		logic        pin;
		sent = 0;
		while (sent < n_items) begin
			if (sb.filt == ST_UNDEF || $urandom_range(99) < 20) begin
				send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
				sent++;
			end else begin
				goal = (sb.filt == ST_LOW) ? ST_HIGH : ST_LOW;
				pin  = (goal == ST_HIGH) ^ sb.invert;
				send_item(OP_SAMPLE, pin);
				sent++;
				if ($urandom_range(99) < 25) begin
					send_item(OP_SAMPLE, ~pin);
					send_item(OP_SAMPLE, pin);
					sent += 2;
				end
				hold  = (goal == ST_HIGH) ? sb.rise_ticks : sb.fall_ticks;
				ticks = $urandom_range((hold > 10) ? 12 : hold + 2, 0);
				repeat (ticks) begin
					send_item(OP_TICK, 1'($urandom_range(1)));
					sent++;
				end
			end
		end
	endtask

	initial begin
		logic [15:0] rise_set [6];
		logic [15:0] fall_set [6];
		logic        inv_set  [6];
		rise_set = '{16'd3, 16'd0, 16'd1, 16'hFFFF, 16'd5, 16'd0};
		fall_set = '{16'd5, 16'd7, 16'd0, 16'd2, 16'hFFFF, 16'd0};
		inv_set  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, still with no idling on either side.
		configure(16'd2, 16'd3, 1'b0);
		send_item(OP_TICK, 1'b0);       // tick before anything is defined
		send_item(OP_SAMPLE, 1'b1);     // first edge defines the state as low
		send_item(OP_SAMPLE, 1'b1);     // repeated level is ignored
		send_item(OP_TICK, 1'b1);       // tick with no countdown; pin is don't-care
		send_item(OP_SAMPLE, 1'b0);     // back at the filtered level
		send_item(OP_SAMPLE, 1'b1);     // rising edge loads the rise delay
		send_item(OP_TICK, 1'b0);
		send_item(OP_SAMPLE, 1'b0);     // bounce cancels the countdown
		send_item(OP_SAMPLE, 1'b1);     // reload
		send_item(OP_TICK, 1'b0);
		send_item(OP_TICK, 1'b1);       // expiry: state goes high
		send_item(OP_SAMPLE, 1'b0);     // falling edge loads the fall delay
		send_item(OP_TICK, 1'b0);
		send_item(OP_SAMPLE, 1'b1);     // cancel
		send_item(OP_SAMPLE, 1'b0);     // reload, left running over the writes
		drain();

		// Zero rise delay, largest fall delay, inverted pin.
		configure(16'd0, 16'hFFFF, 1'b1);
		send_item(OP_TICK, 1'b0);       // the running countdown keeps its old load
		send_item(OP_TICK, 1'b1);
		send_item(OP_TICK, 1'b0);       // expiry: state goes low
		send_item(OP_SAMPLE, 1'b0);     // inverted to high: zero delay toggles at once
		send_item(OP_SAMPLE, 1'b1);     // inverted to low: loads the largest delay
		send_item(OP_TICK, 1'b1);
		send_item(OP_SAMPLE, 1'b0);     // cancel
		drain();

		// Random phases, each with its own delays and one of four handshake pressures.
		for (int p = 0; p < 6; p++) begin
			configure(rise_set[p], fall_set[p], inv_set[p]);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 53;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 53;
				end
				default: begin
					send_idle_pct  = 21;
					recv_stall_pct = 21;
				end
			endcase
			run_random(PHASE_ITEMS);
			drain();
		end

		// Give a stray late result time to show up before the verdict.
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.expected_levels.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, even with the heaviest
	// idling and stalling.
	initial begin
		#500000;
		$display("FAILURE");
		$finish;
	end

endmodule
